// ----- sv/charlieplex_rgb_pattern_driver_core_assert.svh -----
// assertion macros for the charlieplex rgb pattern driver core
// expects signals named clock and reset in the including module
`ifndef CHARLIEPLEX_RGB_PATTERN_DRIVER_CORE_ASSERT_SVH
`define CHARLIEPLEX_RGB_PATTERN_DRIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CRPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define CRPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CRPD_ASSERT(label, prop, msg)
`define CRPD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/crpd_pkg.sv -----
// shared types, constants and lookup functions for the charlieplex rgb driver
// no dependencies
package crpd_pkg;

   localparam logic [4:0] LAST_PHASE = 5'd26;
   localparam logic [7:0] PORT_A_DIR_BASE = 8'h48;
   localparam logic [7:0] PORT_B_DIR_BASE = 8'h04;
   localparam logic [7:0] STATUS_RESET = 8'h40;
   localparam logic [7:0] STATUS_ALIVE = 8'h40;
   localparam logic [7:0] STATUS_IR = 8'h08;
   localparam logic [15:0] RANDOM_MASK = 16'h0018;
   localparam logic [4:0] NUM_POSITIONS = 5'd24;

   localparam logic [2:0] CSR_CHASE_FIRST = 3'd0;
   localparam logic [2:0] CSR_CHASE_SECOND = 3'd1;
   localparam logic [2:0] CSR_CHASE_THIRD = 3'd2;
   localparam logic [2:0] CSR_COLOR_PERIOD = 3'd3;
   localparam logic [2:0] CSR_SILENCE_TIMEOUT = 3'd4;

   localparam logic [7:0] CHASE_FIRST_RESET = 8'd113;
   localparam logic [7:0] CHASE_SECOND_RESET = 8'd11;
   localparam logic [7:0] CHASE_THIRD_RESET = 8'd9;
   localparam logic [7:0] COLOR_PERIOD_RESET = 8'd253;
   localparam logic [15:0] SILENCE_TIMEOUT_RESET = 16'd4444;

   localparam logic [7:0] PIN_PAIRS [72] = '{
      8'h42, 8'h24, 8'h71, 8'h17, 8'h41, 8'h14, 8'h72, 8'h27, 8'h53, 8'h35, 8'h93, 8'h39,
      8'h98, 8'h89, 8'h58, 8'h85, 8'h28, 8'h82, 8'h74, 8'h47, 8'h75, 8'h57, 8'h96, 8'h69,
      8'h32, 8'h25, 8'h61, 8'h19, 8'h31, 8'h15, 8'h62, 8'h29, 8'h43, 8'h36, 8'h73, 8'h45,
      8'h78, 8'h12, 8'h48, 8'h86, 8'h18, 8'h83, 8'h64, 8'h49, 8'h65, 8'h59, 8'h76, 8'h79,
      8'h52, 8'h23, 8'h91, 8'h16, 8'h51, 8'h13, 8'h92, 8'h26, 8'h63, 8'h34, 8'h54, 8'h37,
      8'h21, 8'h87, 8'h68, 8'h84, 8'h38, 8'h81, 8'h94, 8'h46, 8'h95, 8'h56, 8'h97, 8'h67
   };

   localparam logic [5:0] COLOR_SEQ [12] = '{
      6'h03, 6'h07, 6'h0a, 6'h0d, 6'h0c, 6'h1c, 6'h28, 6'h34, 6'h30, 6'h31, 6'h22, 6'h13
   };

   typedef struct packed {
      logic [1:0] led;
      logic [1:0] comp;
      logic       high_bit;
   } phase_slot_type;

   typedef struct packed {
      logic [7:0] a_data;
      logic [7:0] a_dir;
      logic [7:0] b_data;
      logic [7:0] b_dir;
   } port_bytes_type;

   // pin code to port bit: 1..7 on port b, 8 and 9 on port a
   function automatic logic [7:0] pin_bit(input logic [3:0] code);
      logic [7:0] bits;
      case (code)
         4'd1: bits = 8'h01;
         4'd2: bits = 8'h02;
         4'd3: bits = 8'h08;
         4'd4: bits = 8'h10;
         4'd5: bits = 8'h20;
         4'd6: bits = 8'h40;
         4'd7: bits = 8'h80;
         4'd8: bits = 8'h01;
         4'd9: bits = 8'h80;
         default: bits = 8'h00;
      endcase
      return bits;
   endfunction

   function automatic phase_slot_type slot_of(input logic [4:0] phase);
      logic [4:0] q;
      phase_slot_type slot;
      if (phase < 5'd9) begin
         q = phase;
      end else if (phase < 5'd18) begin
         q = phase - 5'd9;
      end else begin
         q = phase - 5'd18;
      end
      slot.high_bit = (phase >= 5'd9);
      if (q < 5'd3) begin
         slot.led = 2'd0;
         slot.comp = q[1:0];
      end else if (q < 5'd6) begin
         slot.led = 2'd1;
         slot.comp = 2'(q - 5'd3);
      end else begin
         slot.led = 2'd2;
         slot.comp = 2'(q - 5'd6);
      end
      return slot;
   endfunction

   // sequence index below 24, taken modulo 12
   function automatic logic [5:0] color_at(input logic [4:0] idx);
      logic [4:0] v;
      v = (idx >= 5'd12) ? idx - 5'd12 : idx;
      return COLOR_SEQ[v[3:0]];
   endfunction

endpackage

// ----- sv/charlieplex_rgb_pattern_driver_core.sv -----
// charlieplex rgb pattern driver: one display tick per beat
// the result is registered in the cycle after the input beat is taken
// throughput: one beat per cycle while rsp_ready is high; a single result register with ready passthrough
// reset: synchronous, active high; state, settings and result valid return to defaults
// depends on crpd_pkg, crpd_port_decode and the assertion header
`include "charlieplex_rgb_pattern_driver_core_assert.svh"

module charlieplex_rgb_pattern_driver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_ir_seen,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_port_a_data,
   output logic [7:0]  rsp_port_a_dir,
   output logic [7:0]  rsp_port_b_data,
   output logic [7:0]  rsp_port_b_dir,
   output logic        rsp_chaser_active,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [2:0][7:0]  chase_period_ff;
   logic [7:0]       color_period_ff;
   logic [15:0]      silence_timeout_ff;

   logic [4:0]       phase_ff, phase_in;
   logic [2:0][4:0]  led_position_ff, led_position_in;
   logic [2:0][5:0]  led_color_ff, led_color_in;
   logic [2:0][7:0]  move_countdown_ff, move_countdown_in;
   logic [7:0]       color_countdown_ff, color_countdown_in;
   logic [3:0]       color_index_ff, color_index_in;
   logic [15:0]      random_word_ff, random_word_in;
   logic [2:0][4:0]  random_position_ff, random_position_in;
   logic [15:0]      silence_count_ff, silence_count_in;
   logic             mode_flag_ff, mode_flag_in;
   logic [7:0]       status_bits_ff, status_bits_in;
   logic [15:0]      tock_count_ff, tock_count_in;

   logic             rsp_valid_ff;
   crpd_pkg::port_bytes_type rsp_ports_ff;
   logic             rsp_chaser_ff;

   logic             accept;
   crpd_pkg::port_bytes_type ports;
   crpd_pkg::phase_slot_type slot;
   logic [1:0]       rand_lane;
   logic [15:0]      xs;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;

   crpd_port_decode u_decode (
      .phase        (phase_ff),
      .led_position (led_position_ff),
      .led_color    (led_color_ff),
      .status_bits  (status_bits_ff),
      .ports        (ports)
   );

   always_comb begin
      slot = crpd_pkg::slot_of(phase_ff);
      case (phase_ff)
         5'd12, 5'd18: rand_lane = 2'd1;
         5'd14, 5'd20: rand_lane = 2'd2;
         default: rand_lane = 2'd0;
      endcase
      xs = (random_word_ff == 16'd0) ? 16'd1 : random_word_ff;
      xs = xs ^ (xs << 13);
      xs = xs ^ (xs >> 9);
      xs = xs ^ (xs << 7);

      phase_in = (phase_ff < crpd_pkg::LAST_PHASE) ? phase_ff + 5'd1 : 5'd0;
      led_position_in = led_position_ff;
      led_color_in = led_color_ff;
      move_countdown_in = move_countdown_ff;
      color_countdown_in = color_countdown_ff;
      color_index_in = color_index_ff;
      random_word_in = random_word_ff;
      random_position_in = random_position_ff;
      silence_count_in = silence_count_ff;
      mode_flag_in = mode_flag_ff;
      status_bits_in = status_bits_ff;
      tock_count_in = tock_count_ff;

      if (phase_ff <= 5'd8) begin
         for (int k = 0; k < 3; k++) begin
            if (slot.led == 2'(k)) begin
               if (slot.comp == 2'd0) begin
                  move_countdown_in[k] = move_countdown_ff[k] - 8'd1;
               end else if (move_countdown_ff[k] == 8'd0) begin
                  if (slot.comp == 2'd1) begin
                     if (!mode_flag_ff) begin
                        led_position_in[k] = random_position_ff[k];
                     end else if (k == 1) begin
                        led_position_in[k] = (led_position_ff[k] == 5'd0) ? 5'd23
                           : led_position_ff[k] - 5'd1;
                     end else begin
                        led_position_in[k] = (led_position_ff[k] > 5'd22) ? 5'd0
                           : led_position_ff[k] + 5'd1;
                     end
                  end else begin
                     move_countdown_in[k] = chase_period_ff[k];
                  end
               end
            end
         end
      end else if (phase_ff <= 5'd20) begin
         if (phase_ff[0]) begin
            random_word_in = xs;
         end else if ((random_word_ff & crpd_pkg::RANDOM_MASK) != crpd_pkg::RANDOM_MASK) begin
            for (int k = 0; k < 3; k++) begin
               if (rand_lane == 2'(k)) begin
                  random_position_in[k] = random_word_ff[4:0];
               end
            end
         end
      end else begin
         case (phase_ff)
            5'd21: color_countdown_in = color_countdown_ff - 8'd1;
            5'd22: begin
               if (color_countdown_ff == 8'd0) begin
                  color_countdown_in = color_period_ff;
                  color_index_in = (color_index_ff > 4'd10) ? 4'd0 : color_index_ff + 4'd1;
               end
            end
            5'd23: led_color_in[0] = crpd_pkg::color_at({1'b0, color_index_ff});
            5'd24: led_color_in[1] = crpd_pkg::color_at({1'b0, color_index_ff} + 5'd4);
            5'd25: led_color_in[2] = crpd_pkg::color_at({1'b0, color_index_ff} + 5'd8);
            5'd26: begin
               if (silence_count_ff < silence_timeout_ff) begin
                  silence_count_in = silence_count_ff + 16'd1;
                  status_bits_in = status_bits_ff | crpd_pkg::STATUS_ALIVE;
               end else begin
                  mode_flag_in = 1'b0;
                  status_bits_in = 8'h00;
               end
               tock_count_in = tock_count_ff + 16'd1;
            end
            default: ;
         endcase
      end

      if (req_ir_seen) begin
         silence_count_in = 16'd0;
         mode_flag_in = 1'b1;
         status_bits_in = status_bits_in | crpd_pkg::STATUS_IR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chase_period_ff[0] <= crpd_pkg::CHASE_FIRST_RESET;
         chase_period_ff[1] <= crpd_pkg::CHASE_SECOND_RESET;
         chase_period_ff[2] <= crpd_pkg::CHASE_THIRD_RESET;
         color_period_ff <= crpd_pkg::COLOR_PERIOD_RESET;
         silence_timeout_ff <= crpd_pkg::SILENCE_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            crpd_pkg::CSR_CHASE_FIRST: chase_period_ff[0] <= csr_wdata[7:0];
            crpd_pkg::CSR_CHASE_SECOND: chase_period_ff[1] <= csr_wdata[7:0];
            crpd_pkg::CSR_CHASE_THIRD: chase_period_ff[2] <= csr_wdata[7:0];
            crpd_pkg::CSR_COLOR_PERIOD: color_period_ff <= csr_wdata[7:0];
            crpd_pkg::CSR_SILENCE_TIMEOUT: silence_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 5'd0;
         led_position_ff[0] <= 5'd0;
         led_position_ff[1] <= 5'd8;
         led_position_ff[2] <= 5'd16;
         led_color_ff[0] <= 6'h03;
         led_color_ff[1] <= 6'h0c;
         led_color_ff[2] <= 6'h30;
         move_countdown_ff[0] <= crpd_pkg::CHASE_FIRST_RESET;
         move_countdown_ff[1] <= crpd_pkg::CHASE_SECOND_RESET;
         move_countdown_ff[2] <= crpd_pkg::CHASE_THIRD_RESET;
         color_countdown_ff <= crpd_pkg::COLOR_PERIOD_RESET;
         color_index_ff <= 4'd0;
         random_word_ff <= 16'd1;
         random_position_ff <= '0;
         silence_count_ff <= crpd_pkg::SILENCE_TIMEOUT_RESET;
         mode_flag_ff <= 1'b0;
         status_bits_ff <= crpd_pkg::STATUS_RESET;
         tock_count_ff <= 16'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         led_position_ff <= led_position_in;
         led_color_ff <= led_color_in;
         move_countdown_ff <= move_countdown_in;
         color_countdown_ff <= color_countdown_in;
         color_index_ff <= color_index_in;
         random_word_ff <= random_word_in;
         random_position_ff <= random_position_in;
         silence_count_ff <= silence_count_in;
         mode_flag_ff <= mode_flag_in;
         status_bits_ff <= status_bits_in;
         tock_count_ff <= tock_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ports_ff <= ports;
         rsp_chaser_ff <= mode_flag_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_port_a_data = rsp_ports_ff.a_data;
   assign rsp_port_a_dir = rsp_ports_ff.a_dir;
   assign rsp_port_b_data = rsp_ports_ff.b_data;
   assign rsp_port_b_dir = rsp_ports_ff.b_dir;
   assign rsp_chaser_active = rsp_chaser_ff;

   `CRPD_ASSERT(a_phase_range, phase_ff <= crpd_pkg::LAST_PHASE, "phase left the frame")
   `CRPD_ASSERT(a_color_index_range, color_index_ff <= 4'd11, "color index out of range")
   `CRPD_ASSERT(a_position_range, (led_position_ff[0] < 5'd24) && (led_position_ff[1] < 5'd24)
      && (led_position_ff[2] < 5'd24), "led position out of range")
   `CRPD_ASSERT_NEXT(a_ir_sets_chaser, accept && req_ir_seen, rsp_valid && rsp_chaser_active,
      "ir beat did not select chaser mode")

endmodule

// ----- sv/crpd_port_decode.sv -----
// picks the lit element for the current phase and decodes its pin pair
// into port a/b data and direction bytes; uses crpd_pkg
module crpd_port_decode (
   input  logic [4:0]                phase,
   input  logic [2:0][4:0]           led_position,
   input  logic [2:0][5:0]           led_color,
   input  logic [7:0]                status_bits,
   output crpd_pkg::port_bytes_type  ports
);

   crpd_pkg::phase_slot_type slot;
   logic [4:0] pos;
   logic [5:0] color;
   logic [2:0] bit_sel;
   logic       lit;
   logic [6:0] elem;
   logic [7:0] code;
   logic [3:0] hi;
   logic [3:0] lo;

   always_comb begin
      slot = crpd_pkg::slot_of(phase);
      pos = led_position[slot.led];
      color = led_color[slot.led];
      bit_sel = {slot.comp, slot.high_bit};
      lit = (phase <= crpd_pkg::LAST_PHASE) && color[bit_sel]
         && (pos < crpd_pkg::NUM_POSITIONS);
      case (slot.comp)
         2'd0: elem = {2'b00, pos};
         2'd1: elem = {2'b00, pos} + 7'd24;
         default: elem = {2'b00, pos} + 7'd48;
      endcase
      code = lit ? crpd_pkg::PIN_PAIRS[elem] : 8'h00;
      hi = code[7:4];
      lo = code[3:0];

      ports.a_data = status_bits;
      ports.a_dir = crpd_pkg::PORT_A_DIR_BASE;
      ports.b_data = 8'h00;
      ports.b_dir = crpd_pkg::PORT_B_DIR_BASE;
      if (lit) begin
         if (hi inside {[4'd1:4'd7]}) begin
            ports.b_data = crpd_pkg::pin_bit(hi);
            ports.b_dir = crpd_pkg::PORT_B_DIR_BASE | crpd_pkg::pin_bit(hi);
         end else if (hi inside {4'd8, 4'd9}) begin
            ports.a_data = status_bits | crpd_pkg::pin_bit(hi);
            ports.a_dir = crpd_pkg::PORT_A_DIR_BASE | crpd_pkg::pin_bit(hi);
         end
         if (lo == 4'd0) begin
            ports.b_dir = crpd_pkg::PORT_B_DIR_BASE;
         end else if (lo inside {[4'd1:4'd7]}) begin
            ports.b_dir = ports.b_dir | crpd_pkg::pin_bit(lo);
         end else if (lo inside {4'd8, 4'd9}) begin
            ports.a_dir = ports.a_dir | crpd_pkg::pin_bit(lo);
         end
      end
   end

endmodule
